[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Clocked on aclk; the first two forms are masked while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication, outside reset.
`define AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checked during reset too.
`define AST_ALWAYS_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/abh_pkg.sv]
// Package for the affine bucket hash unit: hash constants, pipeline types.
// Used by every module of the block; no dependencies.
package abh_pkg;

    // Lines per row for the row-preserving hash; must be a power of two.
    localparam int unsigned LINES_PER_ROW = 2;

    function automatic int unsigned floor_log2(input int unsigned v);
        int unsigned r;
        int unsigned t;
        r = 0;
        t = v;
        while (t > 1) begin
            t = t >> 1;
            r = r + 1;
        end
        return r;
    endfunction

    localparam int unsigned LG_LINES = floor_log2(LINES_PER_ROW);

    localparam logic [31:0] PAIR0_MUL = 32'h9E37_79B9;
    localparam logic [31:0] PAIR0_ADD = 32'hB7E1_5162;
    localparam logic [31:0] PAIR1_MUL = 32'h6C07_8965;
    localparam logic [31:0] PAIR1_ADD = 32'hCAFE_BABE;
    localparam logic [63:0] LOW_KEEP_MASK = 64'h3;

    localparam logic [32:0] BUCKETS_RESET = 33'd65536;
    localparam logic [32:0] BUCKETS_MIN   = 33'd2;
    localparam logic [32:0] BUCKETS_MAX   = 33'h1_0000_0000;

    // Newton iteration for the inverse mod 2^64, evaluated at elaboration.
    function automatic logic [63:0] inv_mod64(input logic [63:0] a);
        logic [63:0] x;
        x = a;
        for (int i = 0; i < 5; i++) begin
            x = x * (64'd2 - a * x);
        end
        return x;
    endfunction

    localparam logic [63:0] PAIR0_INV = inv_mod64({32'd0, PAIR0_MUL});
    localparam logic [63:0] PAIR1_INV = inv_mod64({32'd0, PAIR1_MUL});

    localparam int unsigned DIV_BITS = 64;

    typedef enum logic [1:0] {
        CMD_FORWARD = 2'd0,
        CMD_REVERSE = 2'd1,
        CMD_ROW     = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    // Sideband that rides along with every item.
    typedef struct packed {
        logic                row_mode;
        logic [LG_LINES-1:0] sh_line;
    } abh_tag_t;

    typedef struct packed {
        logic        valid;
        abh_tag_t    tag;
        logic [63:0] x;
        logic [63:0] c;
        logic [31:0] addend;
        logic [32:0] d;
    } abh_op_t;

    typedef struct packed {
        logic        valid;
        abh_tag_t    tag;
        logic [63:0] pll;
        logic [31:0] plh;
        logic [31:0] phl;
        logic [31:0] addend;
        logic [32:0] d;
    } abh_prod_t;

    typedef struct packed {
        logic        valid;
        abh_tag_t    tag;
        logic [31:0] rem;
        logic [63:0] dvd;
        logic [32:0] d;
    } abh_div_t;

endpackage

[hw/rtl/abh_premul.sv]
// Operand select and 64-bit low product, three register stages.
// Depends on abh_pkg.
module abh_premul (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [1:0]        cmd,
    input  logic              function_select,
    input  logic [63:0]       key,
    input  logic [32:0]       buckets,
    output abh_pkg::abh_div_t out
);

    abh_pkg::abh_op_t   op_reg, op_next;
    abh_pkg::abh_prod_t prod_reg, prod_next;
    abh_pkg::abh_div_t  div_reg, div_next;

    logic [31:0]                   mul;
    logic [31:0]                   add;
    logic [32:0]                   rows;
    logic [63:0]                   origin;
    logic [abh_pkg::LG_LINES-1:0]  in_row;
    logic [abh_pkg::LG_LINES-1:0]  sh_line;

    always_comb begin
        mul  = function_select ? abh_pkg::PAIR1_MUL : abh_pkg::PAIR0_MUL;
        add  = function_select ? abh_pkg::PAIR1_ADD : abh_pkg::PAIR0_ADD;
        rows = buckets >> abh_pkg::LG_LINES;
        // regroup: drop the in-row line bits above the low pair
        origin = ((key >> (2 + abh_pkg::LG_LINES)) << 2) | (key & abh_pkg::LOW_KEEP_MASK);
        in_row = key[2 +: abh_pkg::LG_LINES];
        sh_line = abh_pkg::LG_LINES'(abh_pkg::PAIR0_MUL[abh_pkg::LG_LINES-1:0] * in_row
                  + abh_pkg::PAIR0_ADD[abh_pkg::LG_LINES-1:0]);

        op_next              = '0;
        op_next.valid        = in_valid;
        op_next.tag.sh_line  = sh_line;
        op_next.d            = buckets;
        case (cmd)
            abh_pkg::CMD_FORWARD: begin
                op_next.x      = key;
                op_next.c      = {32'd0, mul};
                op_next.addend = add;
            end
            abh_pkg::CMD_REVERSE: begin
                op_next.x = key + {31'd0, buckets} - {32'd0, add};
                op_next.c = function_select ? abh_pkg::PAIR1_INV : abh_pkg::PAIR0_INV;
            end
            abh_pkg::CMD_ROW: begin
                if (rows != 33'd0) begin
                    op_next.x            = origin;
                    op_next.c            = {32'd0, abh_pkg::PAIR0_MUL};
                    op_next.addend       = abh_pkg::PAIR0_ADD;
                    op_next.d            = rows;
                    op_next.tag.row_mode = 1'b1;
                end else begin
                    // no full row fits: reduce the in-row shuffle alone
                    op_next.addend = 32'(sh_line);
                end
            end
            default: begin
                op_next.x = '0;
            end
        endcase
    end

    always_comb begin
        prod_next        = '0;
        prod_next.valid  = op_reg.valid;
        prod_next.tag    = op_reg.tag;
        prod_next.addend = op_reg.addend;
        prod_next.d      = op_reg.d;
        prod_next.pll    = op_reg.x[31:0] * op_reg.c[31:0];
        prod_next.plh    = 32'(op_reg.x[63:32] * op_reg.c[31:0]);
        prod_next.phl    = 32'(op_reg.x[31:0] * op_reg.c[63:32]);
    end

    always_comb begin
        div_next       = '0;
        div_next.valid = prod_reg.valid;
        div_next.tag   = prod_reg.tag;
        div_next.d     = prod_reg.d;
        div_next.rem   = '0;
        div_next.dvd   = prod_reg.pll + {prod_reg.plh + prod_reg.phl, 32'd0}
                         + {32'd0, prod_reg.addend};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg.valid   <= 1'b0;
            prod_reg.valid <= 1'b0;
            div_reg.valid  <= 1'b0;
        end else if (en) begin
            op_reg   <= op_next;
            prod_reg <= prod_next;
            div_reg  <= div_next;
        end
    end

    assign out = div_reg;

endmodule

[hw/rtl/abh_divstage.sv]
// One restoring-division step: retires one dividend bit into the remainder.
// Depends on abh_pkg.
module abh_divstage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  abh_pkg::abh_div_t in,
    output abh_pkg::abh_div_t out
);

    abh_pkg::abh_div_t q_reg, q_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb begin
        trial  = {in.rem, in.dvd[63]};
        diff   = trial - in.d;
        q_next = in;
        q_next.dvd = in.dvd << 1;
        q_next.rem = (trial >= in.d) ? diff[31:0] : trial[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else if (en) begin
            q_reg <= q_next;
        end
    end

    assign out = q_reg;

endmodule

[hw/rtl/abh_divider.sv]
// Pipelined 64-by-33-bit remainder, one stage per dividend bit.
// Depends on abh_pkg and abh_divstage.
module abh_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  abh_pkg::abh_div_t in,
    output abh_pkg::abh_div_t out
);

    abh_pkg::abh_div_t chain [abh_pkg::DIV_BITS+1];

    assign chain[0] = in;

    for (genvar i = 0; i < abh_pkg::DIV_BITS; i++) begin : g_stage
        abh_divstage u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in      (chain[i]),
            .out     (chain[i+1])
        );
    end

    assign out = chain[abh_pkg::DIV_BITS];

endmodule

[hw/rtl/affine_bucket_hash_unit.sv]
// Affine bucket hash unit: key in, bucket index out, one item per cycle unless stalled.
// Depends on abh_pkg, abh_premul, abh_divider.
//
// Input channel s_*: s_tdata carries the 64-bit key, s_tuser the command
// (bits 1:0) and the hash pair select (bit 2). Output channel m_*: m_tdata
// carries the 32-bit bucket index. cfg_wr_en/cfg_wr_data set the bucket
// count; values below 2 are held as 2, above 2^32 as 2^32. Write it only
// while the pipeline is empty.
//
// The pipeline has three stages of operand select and 32x32 partial
// products, 64 remainder stages (one dividend bit each) and one output
// register. Throughput is one item per cycle while the receiver does not
// stall, set by the remainder pipeline taking a new item every cycle.
//
// Reset clears all valid bits and sets the bucket count to 65536. When the
// receiver stalls with a result waiting, the whole pipeline holds in place
// and s_tready drops; nothing is lost or repeated.
module affine_bucket_hash_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key
    input  logic [2:0]  s_tuser,   // cmd[1:0], function_select[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // bucket_index
    input  logic        cfg_wr_en,
    input  logic [32:0] cfg_wr_data
);

    logic [32:0]       buckets_reg;
    logic [32:0]       buckets_next;
    logic              en;
    abh_pkg::abh_div_t pre_out;
    abh_pkg::abh_div_t div_out;
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;
    logic [31:0]       index_next;

    always_comb begin
        buckets_next = cfg_wr_data;
        if (cfg_wr_data < abh_pkg::BUCKETS_MIN) begin
            buckets_next = abh_pkg::BUCKETS_MIN;
        end else if (cfg_wr_data > abh_pkg::BUCKETS_MAX) begin
            buckets_next = abh_pkg::BUCKETS_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buckets_reg <= abh_pkg::BUCKETS_RESET;
        end else if (cfg_wr_en) begin
            buckets_reg <= buckets_next;
        end
    end

    // advance the pipeline unless a result is held
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    abh_premul u_premul (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .in_valid        (s_tvalid),
        .cmd             (s_tuser[1:0]),
        .function_select (s_tuser[2]),
        .key             (s_tdata),
        .buckets         (buckets_reg),
        .out             (pre_out)
    );

    abh_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in      (pre_out),
        .out     (div_out)
    );

    always_comb begin
        if (div_out.tag.row_mode) begin
            index_next = {div_out.rem[31-abh_pkg::LG_LINES:0], div_out.tag.sh_line};
        end else begin
            index_next = div_out.rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= div_out.valid;
            m_tdata_reg  <= index_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hw/rtl/abh_checker.sv]
// Port-level checks for the affine bucket hash unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module abh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `AST_ALWAYS_NEXT(a_reset_empty, !aresetn, !m_tvalid, "output valid right after reset")
    `AST_SAME(a_ready_follows, 1'b1, s_tready == (!m_tvalid || m_tready),
        "input ready does not track output stall")
    `AST_NEXT(a_valid_hold, m_tvalid && !m_tready, m_tvalid, "output item dropped while stalled")
    `AST_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata),
        "output data changed while stalled")

endmodule

bind affine_bucket_hash_unit abh_checker u_abh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
